>>> rtl/smeu_pkg.sv
// Package for the stack machine execute unit: opcodes, status codes and the
// record that travels from the front part to the back part. No dependencies.
package smeu_pkg;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
		OP_MOD = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_SHL = 5'd9,
		OP_SHR = 5'd10, OP_OUT = 5'd11, OP_IN = 5'd12, OP_STORE = 5'd13,
		OP_LOAD = 5'd14, OP_BZ = 5'd15, OP_BPOS = 5'd16, OP_BNEG = 5'd17,
		OP_JMP = 5'd18, OP_POP = 5'd19, OP_HALT = 5'd20
	} opcode_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNDER   = 3'd1;
	localparam logic [2:0] ST_DIV0    = 3'd2;
	localparam logic [2:0] ST_BADREG  = 3'd3;
	localparam logic [2:0] ST_OVER    = 3'd4;
	localparam logic [2:0] ST_HALT    = 3'd5;
	localparam logic [2:0] ST_NOLABEL = 3'd6;

	localparam int NUM_REGS = 4;

	// instruction classes assigned by the front part
	typedef enum logic [2:0] {
		CL_PUSH, CL_BINARY, CL_UNARY, CL_JMP, CL_POP, CL_HALT
	} iclass_t;

	typedef struct packed {
		logic [4:0]  opcode;
		iclass_t     iclass;
		logic [9:0]  operand;
		logic [31:0] in_value;
		logic [15:0] target_addr;
		logic        target_valid;
		logic        reg_ok;
		logic        is_div;
	} instr_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        out_valid;
		logic [31:0] out_value;
		logic        out_is_number;
		logic        jump;
		logic [15:0] jump_addr;
	} result_t;

endpackage

>>> rtl/smeu_front.sv
// Front part: accepts instructions, classifies them and holds them in a
// two-entry queue for the back part. Depends on smeu_pkg.
module smeu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [4:0]       opcode,
	input  logic [9:0]       operand,
	input  logic [31:0]      in_value,
	input  logic [15:0]      target_addr,
	input  logic             target_valid,
	output logic             q_valid,
	input  logic             q_ready,
	output smeu_pkg::instr_t q_instr
);
	smeu_pkg::instr_t entry_q [2];
	logic             rd_q, wr_q;
	logic [1:0]       cnt_q;
	smeu_pkg::instr_t cls;
	logic             push, pop;

	always_comb begin
		cls.opcode       = opcode;
		cls.operand      = operand;
		cls.in_value     = in_value;
		cls.target_addr  = target_addr;
		cls.target_valid = target_valid;
		cls.reg_ok       = (operand < 10'(smeu_pkg::NUM_REGS));
		cls.is_div       = (opcode == smeu_pkg::OP_DIV) || (opcode == smeu_pkg::OP_MOD);
		unique case (opcode) inside
			smeu_pkg::OP_PUSH, smeu_pkg::OP_IN, smeu_pkg::OP_LOAD: cls.iclass = smeu_pkg::CL_PUSH;
			[smeu_pkg::OP_ADD:smeu_pkg::OP_XOR]:               cls.iclass = smeu_pkg::CL_BINARY;
			smeu_pkg::OP_SHL, smeu_pkg::OP_SHR, smeu_pkg::OP_OUT, smeu_pkg::OP_STORE,
			smeu_pkg::OP_BZ, smeu_pkg::OP_BPOS, smeu_pkg::OP_BNEG:  cls.iclass = smeu_pkg::CL_UNARY;
			smeu_pkg::OP_JMP:                                  cls.iclass = smeu_pkg::CL_JMP;
			smeu_pkg::OP_POP:                                  cls.iclass = smeu_pkg::CL_POP;
			default:                                           cls.iclass = smeu_pkg::CL_HALT;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_instr  = entry_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= cls;
	end
endmodule

>>> rtl/smeu_divider.sv
// Radix-2 restoring divider for signed 32-bit words, one quotient bit per
// cycle; truncating quotient, remainder with the dividend's sign. No deps.
module smeu_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	logic [31:0] quo_q, den_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q, qneg_q, rneg_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[31]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[31] ? -dividend : dividend;
			den_q  <= divisor[31] ? -divisor : divisor;
			rem_q  <= 33'd0;
			qneg_q <= dividend[31] ^ divisor[31];
			rneg_q <= dividend[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient  = qneg_q ? -quo_q : quo_q;
	assign remainder = rneg_q ? -rem_q[31:0] : rem_q[31:0];
endmodule

>>> rtl/smeu_back.sv
// Back part: executes instructions on the operand stack memory, scratch
// registers and divider, and holds one result. Depends on smeu_pkg, smeu_divider.
module smeu_back #(
	parameter int STACK_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  smeu_pkg::instr_t  q_instr,
	output logic              res_valid,
	input  logic              res_ready,
	output smeu_pkg::result_t res
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;

	logic [31:0]       mem [STACK_DEPTH];
	logic [31:0]       rdata_b_q, rdata_a_q;
	logic [31:0]       regs_q [smeu_pkg::NUM_REGS];
	logic [CW-1:0]     count_q;
	logic              halted_q;
	state_t            state_q;
	smeu_pkg::instr_t  ins_q;
	logic [31:0]       prod_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [31:0]       mem_wdata;
	logic              div_start, div_done;
	logic [31:0]       div_q, div_r;
	logic [CW-1:0]     cm1, cm2;

	assign cm1 = count_q - CW'(1);
	assign cm2 = count_q - CW'(2);

	smeu_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(rdata_a_q), .divisor(rdata_b_q),
		.done(div_done), .quotient(div_q), .remainder(div_r)
	);

	assign q_ready = (state_q == S_IDLE) && !res_valid;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_b_q <= mem[cm1[AW-1:0]];
		rdata_a_q <= mem[cm2[AW-1:0]];
		prod_q    <= rdata_a_q * rdata_b_q;
	end

	// execute step: work out the result and the state update
	logic              x_done, x_mul, x_div;
	logic [2:0]        st;
	smeu_pkg::result_t r;
	logic [31:0]       t, alu, pv;
	logic              neg, cond;
	logic [CW-1:0]     ncount;
	logic              reg_we;

	always_comb begin
		t = rdata_b_q;
		neg = t[31];
		st = smeu_pkg::ST_OK;
		r = '0;
		mem_we = 1'b0;
		mem_waddr = cm1[AW-1:0];
		mem_wdata = '0;
		ncount = count_q;
		reg_we = 1'b0;
		cond = 1'b0;
		x_done = 1'b1;
		x_mul = 1'b0;
		x_div = 1'b0;
		div_start = 1'b0;
		alu = '0;
		pv = (ins_q.opcode == smeu_pkg::OP_PUSH) ? 32'(ins_q.operand) : ins_q.in_value;
		if (ins_q.opcode == smeu_pkg::OP_LOAD) pv = regs_q[ins_q.operand[1:0]];
		case (ins_q.opcode)
			smeu_pkg::OP_ADD: alu = rdata_a_q + rdata_b_q;
			smeu_pkg::OP_SUB: alu = rdata_a_q - rdata_b_q;
			smeu_pkg::OP_MUL: alu = prod_q;
			smeu_pkg::OP_DIV: alu = div_q;
			smeu_pkg::OP_MOD: alu = div_r;
			smeu_pkg::OP_AND: alu = rdata_a_q & rdata_b_q;
			smeu_pkg::OP_OR:  alu = rdata_a_q | rdata_b_q;
			default:          alu = rdata_a_q ^ rdata_b_q;
		endcase
		if (halted_q) begin
			st = smeu_pkg::ST_HALT;
		end else begin
			unique case (ins_q.iclass)
				smeu_pkg::CL_PUSH: begin
					if (ins_q.opcode == smeu_pkg::OP_LOAD && !ins_q.reg_ok)
						st = smeu_pkg::ST_BADREG;
					else if (count_q >= CW'(STACK_DEPTH)) st = smeu_pkg::ST_OVER;
					else begin
						mem_we = 1'b1;
						mem_waddr = count_q[AW-1:0];
						mem_wdata = pv;
						ncount = count_q + CW'(1);
					end
				end
				smeu_pkg::CL_BINARY: begin
					if (count_q < CW'(2)) st = smeu_pkg::ST_UNDER;
					else if (ins_q.is_div && rdata_b_q == 32'd0) st = smeu_pkg::ST_DIV0;
					else if (state_q == S_EXEC && ins_q.opcode == smeu_pkg::OP_MUL) begin
						x_done = 1'b0;
						x_mul = 1'b1;
					end else if (state_q == S_EXEC && ins_q.is_div) begin
						x_done = 1'b0;
						x_div = 1'b1;
						div_start = 1'b1;
					end else begin
						mem_we = 1'b1;
						mem_waddr = cm2[AW-1:0];
						mem_wdata = alu;
						ncount = cm1;
					end
				end
				smeu_pkg::CL_UNARY: begin
					if (count_q == '0) st = smeu_pkg::ST_UNDER;
					else begin
						case (ins_q.opcode)
							smeu_pkg::OP_SHL: begin
								mem_we = 1'b1;
								mem_wdata = (ins_q.operand >= 10'd32) ? 32'd0 :
									t << ins_q.operand[4:0];
							end
							smeu_pkg::OP_SHR: begin
								mem_we = 1'b1;
								mem_wdata = (ins_q.operand >= 10'd32) ? {32{neg}} :
									32'($signed(t) >>> ins_q.operand[4:0]);
							end
							smeu_pkg::OP_OUT: begin
								r.out_valid = 1'b1;
								r.out_value = t;
								r.out_is_number = (ins_q.operand == 10'd1);
							end
							smeu_pkg::OP_STORE: begin
								if (!ins_q.reg_ok) st = smeu_pkg::ST_BADREG;
								else begin
									reg_we = 1'b1;
									ncount = cm1;
								end
							end
							default: begin
								if (ins_q.opcode == smeu_pkg::OP_BZ) cond = (t == 32'd0);
								else if (ins_q.opcode == smeu_pkg::OP_BPOS)
									cond = !neg && (t != 32'd0);
								else cond = neg;
								if (cond) begin
									if (ins_q.target_valid) begin
										r.jump = 1'b1;
										r.jump_addr = ins_q.target_addr;
									end else st = smeu_pkg::ST_NOLABEL;
								end
								ncount = cm1;
							end
						endcase
					end
				end
				smeu_pkg::CL_JMP: begin
					if (ins_q.target_valid) begin
						r.jump = 1'b1;
						r.jump_addr = ins_q.target_addr;
					end else st = smeu_pkg::ST_NOLABEL;
				end
				smeu_pkg::CL_POP: begin
					if (ins_q.operand == 10'd1 && count_q != '0) ncount = cm1;
				end
				default: st = smeu_pkg::ST_HALT;
			endcase
		end
		if (st != smeu_pkg::ST_OK && st != smeu_pkg::ST_NOLABEL) begin
			r = '0;
			mem_we = 1'b0;
			reg_we = 1'b0;
			ncount = count_q;
		end
		r.status = st;
		if (!x_done || !(state_q == S_EXEC || state_q == S_DONE)) mem_we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			halted_q  <= 1'b0;
			res_valid <= 1'b0;
			for (int i = 0; i < smeu_pkg::NUM_REGS; i++) regs_q[i] <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid && q_ready) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_MUL:  state_q <= S_DONE;
				S_DIV:  if (div_done) state_q <= S_DONE;
				S_EXEC, S_DONE: begin
					if (x_mul) state_q <= S_MUL;
					else if (x_div) state_q <= S_DIV;
					else begin
						state_q   <= S_IDLE;
						res_valid <= 1'b1;
						res       <= r;
						count_q   <= ncount;
						if (st != smeu_pkg::ST_OK && st != smeu_pkg::ST_NOLABEL)
							halted_q <= 1'b1;
						if (reg_we) regs_q[ins_q.operand[1:0]] <= t;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) ins_q <= q_instr;
	end
endmodule

>>> rtl/stack_machine_execute_unit.sv
// Stack machine execute unit: one instruction in, one result out.
// Every instruction passes the stack read and execute steps; mul adds a
// registered multiply and div/mod wait on the one-bit-per-cycle divider.
// The back part runs one instruction at a time behind a two-entry queue.
// Reset: arst_n clears stack count, scratch registers, halted flag and queues.
module stack_machine_execute_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: opcode[4:0], operand[14:5], in_value[46:15], target_addr[62:47],
	// target_valid[63]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: status[2:0], out_valid[3], out_value[35:4], out_is_number[36],
	// jump[37], jump_addr[53:38], zero fill to 56
	output logic [55:0] m_tdata
);
	logic              q_valid, q_ready;
	smeu_pkg::instr_t  q_instr;
	smeu_pkg::result_t res;

	// front: accept and classify each transfer
	smeu_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.opcode(s_tdata[4:0]), .operand(s_tdata[14:5]), .in_value(s_tdata[46:15]),
		.target_addr(s_tdata[62:47]), .target_valid(s_tdata[63]),
		.q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr)
	);

	// back: execute against the stack and hold the result
	smeu_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {2'b00, res.jump_addr, res.jump, res.out_is_number,
		res.out_value, res.out_valid, res.status};
endmodule

>>> tb/stack_machine_execute_unit_check.sv
`timescale 1ns / 1ps
// Checker for the stack machine execute unit: watches both stream channels,
// predicts each result from its own copy of the stack state, and compares.
// Depends on smeu_pkg for opcodes, status codes and the result record.
module stack_machine_execute_unit_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	output int          errors,
	output int          pending
);

	localparam int DEPTH = 64;

	logic [31:0]       stack_words [DEPTH];
	int                stack_level;
	logic [31:0]       scratch [smeu_pkg::NUM_REGS];
	bit                stopped;
	smeu_pkg::result_t expected_results [$];

	// Work out the result of one instruction and advance the shadow state.
	task automatic execute_instr(input logic [63:0] d, output smeu_pkg::result_t r);
		logic [4:0]  op;
		logic [9:0]  imm;
		logic [31:0] inv, a, b, t, v;
		logic [15:0] taddr;
		logic        tv, cond, neg;
		longint      sa, sb;
		logic [2:0]  st;
		op    = d[4:0];
		imm   = d[14:5];
		inv   = d[46:15];
		taddr = d[62:47];
		tv    = d[63];
		r     = '0;
		r.status = smeu_pkg::ST_OK;
		if (stopped) begin
			r.status = smeu_pkg::ST_HALT;
		end else if (op == smeu_pkg::OP_PUSH || op == smeu_pkg::OP_IN ||
				op == smeu_pkg::OP_LOAD) begin
			v = (op == smeu_pkg::OP_PUSH) ? 32'(imm) : inv;
			if (op == smeu_pkg::OP_LOAD) begin
				if (imm >= smeu_pkg::NUM_REGS) r.status = smeu_pkg::ST_BADREG;
				else v = scratch[imm[1:0]];
			end
			if (r.status == smeu_pkg::ST_OK && stack_level >= DEPTH)
				r.status = smeu_pkg::ST_OVER;
			if (r.status == smeu_pkg::ST_OK) begin
				stack_words[stack_level] = v;
				stack_level++;
			end
		end else if (op >= smeu_pkg::OP_ADD && op <= smeu_pkg::OP_XOR) begin
			if (stack_level < 2) begin
				r.status = smeu_pkg::ST_UNDER;
			end else begin
				b = stack_words[stack_level-1];
				a = stack_words[stack_level-2];
				sa = longint'($signed(a));
				sb = longint'($signed(b));
				if ((op == smeu_pkg::OP_DIV || op == smeu_pkg::OP_MOD) && b == 0) begin
					r.status = smeu_pkg::ST_DIV0;
				end else begin
					case (op)
						smeu_pkg::OP_ADD: v = a + b;
						smeu_pkg::OP_SUB: v = a - b;
						smeu_pkg::OP_MUL: v = a * b;
						smeu_pkg::OP_DIV: v = 32'(sa / sb);
						smeu_pkg::OP_MOD: v = 32'(sa % sb);
						smeu_pkg::OP_AND: v = a & b;
						smeu_pkg::OP_OR:  v = a | b;
						default: v = a ^ b;
					endcase
					stack_level--;
					stack_words[stack_level-1] = v;
				end
			end
		end else if (op == smeu_pkg::OP_SHL || op == smeu_pkg::OP_SHR ||
				op == smeu_pkg::OP_OUT || op == smeu_pkg::OP_STORE ||
				(op >= smeu_pkg::OP_BZ && op <= smeu_pkg::OP_BNEG)) begin
			if (stack_level == 0) begin
				r.status = smeu_pkg::ST_UNDER;
			end else begin
				t   = stack_words[stack_level-1];
				neg = t[31];
				if (op == smeu_pkg::OP_SHL) begin
					stack_words[stack_level-1] = (imm >= 32) ? 32'd0 : t << imm;
				end else if (op == smeu_pkg::OP_SHR) begin
					stack_words[stack_level-1] = (imm >= 32) ? {32{neg}} :
						32'($signed(t) >>> imm);
				end else if (op == smeu_pkg::OP_OUT) begin
					r.out_valid     = 1'b1;
					r.out_value     = t;
					r.out_is_number = (imm == 1);
				end else if (op == smeu_pkg::OP_STORE) begin
					if (imm >= smeu_pkg::NUM_REGS) begin
						r.status = smeu_pkg::ST_BADREG;
					end else begin
						scratch[imm[1:0]] = t;
						stack_level--;
					end
				end else begin
					if (op == smeu_pkg::OP_BZ) cond = (t == 0);
					else if (op == smeu_pkg::OP_BPOS) cond = !neg && t != 0;
					else cond = neg;
					if (cond) begin
						if (tv) begin
							r.jump      = 1'b1;
							r.jump_addr = taddr;
						end else begin
							r.status = smeu_pkg::ST_NOLABEL;
						end
					end
					stack_level--;
				end
			end
		end else if (op == smeu_pkg::OP_JMP) begin
			if (tv) begin
				r.jump      = 1'b1;
				r.jump_addr = taddr;
			end else begin
				r.status = smeu_pkg::ST_NOLABEL;
			end
		end else if (op == smeu_pkg::OP_POP) begin
			if (imm == 1 && stack_level > 0) stack_level--;
		end else begin
			// halt and every unknown opcode
			r.status = smeu_pkg::ST_HALT;
		end
		if (r.status != smeu_pkg::ST_OK && r.status != smeu_pkg::ST_NOLABEL) begin
			stopped = 1'b1;
			st = r.status;
			r = '0;
			r.status = st;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		smeu_pkg::result_t exp_r, got_r, tmp_r;
		if (!arst_n) begin
			stack_level = 0;
			stopped     = 1'b0;
			for (int i = 0; i < smeu_pkg::NUM_REGS; i++) scratch[i] = '0;
			expected_results.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				execute_instr(s_tdata, tmp_r);
				expected_results.push_back(tmp_r);
			end
			if (m_tvalid && m_tready) begin
				got_r.status        = m_tdata[2:0];
				got_r.out_valid     = m_tdata[3];
				got_r.out_value     = m_tdata[35:4];
				got_r.out_is_number = m_tdata[36];
				got_r.jump          = m_tdata[37];
				got_r.jump_addr     = m_tdata[53:38];
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: %h", m_tdata);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got_r.status !== exp_r.status)
						$error("status: expected %0d, got %0d", exp_r.status, got_r.status);
					if (got_r.out_valid !== exp_r.out_valid)
						$error("out_valid: expected %0d, got %0d", exp_r.out_valid,
							got_r.out_valid);
					if (got_r.out_value !== exp_r.out_value)
						$error("out_value: expected %h, got %h", exp_r.out_value,
							got_r.out_value);
					if (got_r.out_is_number !== exp_r.out_is_number)
						$error("out_is_number: expected %0d, got %0d", exp_r.out_is_number,
							got_r.out_is_number);
					if (got_r.jump !== exp_r.jump)
						$error("jump: expected %0d, got %0d", exp_r.jump, got_r.jump);
					if (got_r.jump_addr !== exp_r.jump_addr)
						$error("jump_addr: expected %h, got %h", exp_r.jump_addr,
							got_r.jump_addr);
					if (got_r !== exp_r) errors <= errors + 1;
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

>>> tb/stack_machine_execute_unit_test.sv
`timescale 1ns / 1ps
// Top of the stack machine execute unit testbench: clock, reset, instruction
// stimulus, back-pressure and verdict. Depends on smeu_pkg and the checker.
module stack_machine_execute_unit_test;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// tdata: opcode, operand, in_value, target_addr, target_valid
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// tdata: status, out_valid, out_value, out_is_number, jump, jump_addr
	logic [55:0] m_tdata;
	int          errors;
	int          pending;

	// stimulus side bookkeeping
	int depth;        // stack level as the sender sees it
	int sent;         // instructions transferred so far
	int send_idle;    // percent of cycles the sender idles
	int recv_idle;    // percent of cycles the receiver idles
	bit squeeze_req;
	bit squeeze_done;

	stack_machine_execute_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	stack_machine_execute_unit_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// Offer one instruction and hold it until the transfer; track stack level
	// the way a non-faulting run moves it.
	task automatic issue(input smeu_pkg::opcode_t op, input logic [9:0] imm,
			input logic [31:0] inv, input logic tv);
		logic [15:0] taddr;
		taddr = 16'($urandom);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {tv, taddr, inv, imm, 5'(op)};
		do @(posedge clk); while (!s_tready);
		sent++;
		case (op)
			smeu_pkg::OP_PUSH, smeu_pkg::OP_IN, smeu_pkg::OP_LOAD: depth++;
			smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
			smeu_pkg::OP_MOD, smeu_pkg::OP_AND, smeu_pkg::OP_OR, smeu_pkg::OP_XOR,
			smeu_pkg::OP_STORE, smeu_pkg::OP_BZ, smeu_pkg::OP_BPOS,
			smeu_pkg::OP_BNEG: depth--;
			smeu_pkg::OP_POP: if (imm == 1 && depth > 0) depth--;
			default: ;
		endcase
		// set idling phases by progress
		if (sent < 600) begin
			send_idle = 11; recv_idle = 46;
		end else if (sent < 1200) begin
			send_idle = 46; recv_idle = 11;
		end else begin
			send_idle = 0; recv_idle = 0;
		end
		if (sent == 1300) squeeze_req = 1'b1;
	endtask

	// Receiver: random back-pressure, plus one long hold-off so the block
	// fills up and stalls its input.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		int          r, k;
		logic [31:0] w;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		depth        = 0;
		sent         = 0;
		send_idle    = 11;
		recv_idle    = 46;
		squeeze_req  = 1'b0;
		squeeze_done = 1'b0;
		arst_n       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every operation but bpos, bneg and halt, and the non-fatal corner cases.
		issue(smeu_pkg::OP_POP, 10'd1, '0, 1'b1);            // pop on an empty stack
		issue(smeu_pkg::OP_PUSH, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_PUSH, 10'd999, '0, 1'b1);
		issue(smeu_pkg::OP_ADD, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_PUSH, 10'd1023, '0, 1'b1);       // operand above the decimal range
		issue(smeu_pkg::OP_SUB, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_IN, 10'd0, 32'h7fffffff, 1'b1);
		issue(smeu_pkg::OP_MUL, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_OUT, 10'd1, '0, 1'b1);
		issue(smeu_pkg::OP_OUT, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_IN, 10'd0, 32'h80000000, 1'b1);   // most negative over minus one
		issue(smeu_pkg::OP_IN, 10'd0, 32'hffffffff, 1'b1);
		issue(smeu_pkg::OP_DIV, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_IN, 10'd0, 32'h80000000, 1'b1);
		issue(smeu_pkg::OP_IN, 10'd0, 32'hffffffff, 1'b1);
		issue(smeu_pkg::OP_MOD, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_AND, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_PUSH, 10'd7, '0, 1'b1);
		issue(smeu_pkg::OP_OR, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_PUSH, 10'd5, '0, 1'b1);
		issue(smeu_pkg::OP_XOR, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_SHL, 10'd31, '0, 1'b1);
		issue(smeu_pkg::OP_SHR, 10'd32, '0, 1'b1);            // wide arithmetic shift
		issue(smeu_pkg::OP_SHL, 10'd40, '0, 1'b1);            // wide left shift
		issue(smeu_pkg::OP_STORE, 10'd3, '0, 1'b1);
		issue(smeu_pkg::OP_LOAD, 10'd3, '0, 1'b1);
		issue(smeu_pkg::OP_BZ, 10'd0, '0, 1'b0);              // taken, label missing
		issue(smeu_pkg::OP_JMP, 10'd0, '0, 1'b1);
		issue(smeu_pkg::OP_JMP, 10'd0, '0, 1'b0);
		issue(smeu_pkg::OP_POP, 10'd2, '0, 1'b1);             // selector other than one

		// Random: well-formed programs that never fault.
		while (sent < 1530) begin
			r = $urandom_range(99);
			w = $urandom;
			if (depth < 2 || (r < 30 && depth < 60)) begin
				k = $urandom_range(2);
				if (k == 0)
					issue(smeu_pkg::OP_PUSH,
						($urandom_range(7) == 0) ? 10'd0 : 10'($urandom), '0, 1'b1);
				else if (k == 1)
					issue(smeu_pkg::OP_IN, 10'd0,
						($urandom_range(7) == 0) ? 32'd0 : w, 1'b1);
				else
					issue(smeu_pkg::OP_LOAD, 10'($urandom_range(smeu_pkg::NUM_REGS - 1)),
						'0, 1'b1);
			end else if (depth >= 60) begin
				issue(($urandom_range(1) == 0) ? smeu_pkg::OP_ADD : smeu_pkg::OP_POP,
					10'd1, '0, 1'b1);
			end else if (r < 45) begin
				k = $urandom_range(5);
				issue(k == 0 ? smeu_pkg::OP_ADD : k == 1 ? smeu_pkg::OP_SUB :
					k == 2 ? smeu_pkg::OP_MUL : k == 3 ? smeu_pkg::OP_AND :
					k == 4 ? smeu_pkg::OP_OR : smeu_pkg::OP_XOR, 10'($urandom), '0, 1'b1);
			end else if (r < 53) begin
				// guard the divisor with a fresh non-zero word
				if (w == 0) w = 32'd1;
				issue(smeu_pkg::OP_IN, 10'd0, w, 1'b1);
				issue(($urandom_range(1) == 0) ? smeu_pkg::OP_DIV : smeu_pkg::OP_MOD,
					10'($urandom), '0, 1'b1);
			end else if (r < 63) begin
				issue(($urandom_range(1) == 0) ? smeu_pkg::OP_SHL : smeu_pkg::OP_SHR,
					($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(40)),
					'0, 1'b1);
			end else if (r < 70) begin
				issue(smeu_pkg::OP_OUT, ($urandom_range(1) == 0) ? 10'd1 : 10'($urandom),
					w, 1'b1);
			end else if (r < 76) begin
				issue(smeu_pkg::OP_STORE, 10'($urandom_range(smeu_pkg::NUM_REGS - 1)),
					'0, 1'b1);
			end else if (r < 88) begin
				k = $urandom_range(2);
				issue(k == 0 ? smeu_pkg::OP_BZ : k == 1 ? smeu_pkg::OP_BPOS :
					smeu_pkg::OP_BNEG, 10'($urandom), w, $urandom_range(9) != 0);
			end else if (r < 94) begin
				issue(smeu_pkg::OP_JMP, 10'($urandom), w, $urandom_range(9) != 0);
			end else begin
				issue(smeu_pkg::OP_POP, ($urandom_range(3) != 0) ? 10'd1 : 10'($urandom),
					'0, 1'b1);
			end
		end

		// One fatal fault to close the run, then show the halted answer.
		k = $urandom_range(5);
		case (k)
			0: begin
				while (depth > 0) issue(smeu_pkg::OP_POP, 10'd1, '0, 1'b1);
				issue(smeu_pkg::OP_ADD, 10'd0, '0, 1'b1);
			end
			1: begin
				issue(smeu_pkg::OP_PUSH, 10'd3, '0, 1'b1);
				issue(smeu_pkg::OP_PUSH, 10'd0, '0, 1'b1);
				issue(($urandom_range(1) == 0) ? smeu_pkg::OP_DIV : smeu_pkg::OP_MOD,
					10'd0, '0, 1'b1);
			end
			2: begin
				issue(smeu_pkg::OP_PUSH, 10'd1, '0, 1'b1);
				issue(($urandom_range(1) == 0) ? smeu_pkg::OP_STORE : smeu_pkg::OP_LOAD,
					10'($urandom_range(1023, smeu_pkg::NUM_REGS)), '0, 1'b1);
			end
			3: begin
				while (depth < 64) issue(smeu_pkg::OP_PUSH, 10'($urandom), '0, 1'b1);
				issue(smeu_pkg::OP_IN, 10'd0, $urandom, 1'b1);
			end
			4: issue(smeu_pkg::OP_HALT, 10'd0, '0, 1'b1);
			default: issue(smeu_pkg::opcode_t'($urandom_range(31, 21)), 10'd0, '0, 1'b1);
		endcase
		repeat (6) issue(smeu_pkg::opcode_t'($urandom_range(31)), 10'($urandom),
			$urandom, 1'b1);
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain, then let the pipeline settle past a divide.
		while (pending != 0 || m_tvalid) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/smeu_pkg.sv
rtl/smeu_front.sv
rtl/smeu_divider.sv
rtl/smeu_back.sv
rtl/stack_machine_execute_unit.sv
tb/stack_machine_execute_unit_check.sv
tb/stack_machine_execute_unit_test.sv
